[sv/led_pkg.sv]
// Package for the local extremum detector: sizes, register indexes,
// sample and job types, and the sequencer state type.
// No dependencies.
package led_pkg;

  localparam int MAX_ORDER   = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int CELLS       = 2 * MAX_ORDER;

  localparam int ORDER_W = 5;
  localparam int COUNT_W = 17;
  localparam int PHASE_W = 4;
  localparam int STEP_W  = 4;
  localparam int THR_W   = 17;
  localparam int INDEX_W = 16;
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int ACC_W   = DIFF_W + 4;
  localparam int MAG_W   = ACC_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               find_max;
    logic [THR_W-1:0]   threshold;
    logic [INDEX_W-1:0] cand_index;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DECIDE
  } seq_state_t;

endpackage

[sv/led_cell.sv]
// One cell of the sample line: holds one sample, passes it to the next cell
// on a shift, and forms the difference from the candidate sample.
// Depends on led_pkg.
module led_cell (
  input  logic            clk,
  input  logic            shift,
  input  led_pkg::sample_t din,
  input  led_pkg::sample_t xc,
  output led_pkg::sample_t dout,
  output led_pkg::diff_t   diff
);

  led_pkg::sample_t sample_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_q <= din;
    end
  end

  assign dout = sample_q;
  assign diff = led_pkg::diff_t'(xc) - led_pkg::diff_t'(sample_q);

endmodule

[sv/led_accum.sv]
// Test sequencer: walks the neighbor pairs of one candidate, accumulates the
// left and right sums, applies the threshold and holds the result register.
// Depends on led_pkg.
module led_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  led_pkg::job_t                 job,
  input  led_pkg::sample_t              taps [led_pkg::CELLS],
  input  led_pkg::diff_t                diffs [led_pkg::CELLS],
  output led_pkg::sample_t              xc,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [led_pkg::INDEX_W-1:0]   peak_index
);

  led_pkg::seq_state_t state, state_next;
  led_pkg::job_t job_q;
  logic [led_pkg::STEP_W-1:0] step;
  led_pkg::acc_t left, right;
  logic [led_pkg::MAG_W-1:0] thr_scaled;

  logic [led_pkg::ORDER_W-1:0] lsel, rsel;
  logic last_step;
  led_pkg::acc_t ls, rs;
  logic signed [led_pkg::MAG_W-1:0] gap;
  logic [led_pkg::MAG_W-1:0] mag;
  logic pass, slot_busy;

  assign xc = taps[job_q.order];
  assign lsel = job_q.order + led_pkg::ORDER_W'(step);
  assign rsel = job_q.order - led_pkg::ORDER_W'(step);
  assign last_step = (led_pkg::ORDER_W'(step) == job_q.order - 5'd1);

  assign ls = job_q.find_max ? -left : left;
  assign rs = job_q.find_max ? -right : right;
  assign gap = led_pkg::MAG_W'(ls) - led_pkg::MAG_W'(rs);
  assign mag = gap[led_pkg::MAG_W-1] ? led_pkg::MAG_W'(-gap) : led_pkg::MAG_W'(gap);
  assign pass = ls[led_pkg::ACC_W-1] && rs[led_pkg::ACC_W-1] && (mag > thr_scaled);
  assign slot_busy = out_valid && !out_ready;

  always_comb begin
    state_next = state;
    case (state)
      led_pkg::ST_IDLE: begin
        if (start) begin
          state_next = led_pkg::ST_ACCUM;
        end
      end
      led_pkg::ST_ACCUM: begin
        if (last_step) begin
          state_next = led_pkg::ST_DECIDE;
        end
      end
      led_pkg::ST_DECIDE: begin
        if (!(pass && slot_busy)) begin
          state_next = led_pkg::ST_IDLE;
        end
      end
      default: state_next = led_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      led_pkg::ST_IDLE: busy = 1'b0;
      default:          busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= led_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == led_pkg::ST_DECIDE && pass && !slot_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_q <= job;
      step  <= '0;
      left  <= '0;
      right <= '0;
    end else if (state == led_pkg::ST_ACCUM) begin
      step       <= step + 4'd1;
      left       <= left + led_pkg::acc_t'(diffs[lsel]);
      right      <= right + led_pkg::acc_t'(diffs[rsel]);
      thr_scaled <= led_pkg::MAG_W'(job_q.threshold) * led_pkg::MAG_W'(job_q.order);
    end
    if (state == led_pkg::ST_DECIDE && pass && !slot_busy) begin
      peak_index <= job_q.cand_index;
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == led_pkg::ST_IDLE)
    else $error("test started while sequencer busy");

  a_start_accum: assert property (@(posedge clk) disable iff (rst)
    start |=> state == led_pkg::ST_ACCUM)
    else $error("start did not enter accumulation");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == led_pkg::ST_ACCUM |-> led_pkg::ORDER_W'(step) < job_q.order)
    else $error("step counter ran past the order");

  a_decide_done: assert property (@(posedge clk) disable iff (rst)
    (state == led_pkg::ST_DECIDE && !slot_busy) |=> state == led_pkg::ST_IDLE)
    else $error("decision did not retire");
`endif

endmodule

[sv/local_extremum_detector_core.sv]
// Local extremum detector top level: configuration registers, sample
// counter and stride phase, the line of sample cells and the test sequencer.
// Depends on led_pkg, led_cell and led_accum.
//
// Samples stream in one per cycle unless a test holds them; every order-th
// sample from index 2*order on tests the candidate order samples back. A
// sample that triggers a test holds the input while the sequencer is busy
// (accept, a step per neighbor pair, the decision); other samples pass on.
// A detected index sits in an output register, so input transfers continue
// while it waits; a further detection made while that register is still
// full holds in the decision state, and the input with it, until the
// waiting index transfers. No clearing pass is needed after reset.
module local_extremum_detector_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [led_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [led_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [led_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [led_pkg::INDEX_W-1:0]       peak_index
);

  logic [led_pkg::ORDER_W-1:0] window_order;
  logic                        extremum_mode;
  logic [led_pkg::THR_W-1:0]   threshold;
  logic [led_pkg::COUNT_W-1:0] sample_count;
  logic [led_pkg::PHASE_W-1:0] stride_phase;

  logic [led_pkg::ORDER_W-1:0] order_eff;
  logic [led_pkg::ORDER_W:0]   phase_inc;
  logic in_xfer, stored, start, busy;
  led_pkg::job_t job;
  led_pkg::sample_t xc;
  led_pkg::sample_t taps [led_pkg::CELLS];
  led_pkg::diff_t   diffs [led_pkg::CELLS];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_xfer   = in_valid && in_ready;

  assign order_eff = (window_order == '0) ? 5'd1 :
                     (window_order > 5'(led_pkg::MAX_ORDER)) ? 5'(led_pkg::MAX_ORDER) :
                     window_order;
  assign stored    = (sample_count < led_pkg::COUNT_W'(led_pkg::MAX_SAMPLES));
  assign phase_inc = {1'b0, 5'(stride_phase) + 5'd1};
  assign start     = in_xfer && stored && (stride_phase == '0) &&
                     (sample_count >= led_pkg::COUNT_W'({order_eff, 1'b0}));

  assign job.order      = order_eff;
  assign job.find_max   = extremum_mode;
  assign job.threshold  = threshold;
  assign job.cand_index = sample_count[led_pkg::INDEX_W-1:0] -
                          led_pkg::INDEX_W'(order_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_order  <= 5'd1;
      extremum_mode <= 1'b0;
      threshold     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        led_pkg::REG_ORDER:     window_order  <= cfg_data[led_pkg::ORDER_W-1:0];
        led_pkg::REG_MODE:      extremum_mode <= cfg_data[0];
        led_pkg::REG_THRESHOLD: threshold     <= cfg_data[led_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      stride_phase <= '0;
    end else if (in_xfer) begin
      if (last) begin
        sample_count <= '0;
        stride_phase <= '0;
      end else if (stored) begin
        sample_count <= sample_count + 17'd1;
        stride_phase <= (phase_inc >= 6'(order_eff)) ? '0 :
                        phase_inc[led_pkg::PHASE_W-1:0];
      end
    end
  end

  for (genvar i = 0; i < led_pkg::CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      led_cell u_cell (
        .clk   (clk),
        .shift (in_xfer && stored),
        .din   (sample),
        .xc    (xc),
        .dout  (taps[i]),
        .diff  (diffs[i])
      );
    end else begin : g_body
      led_cell u_cell (
        .clk   (clk),
        .shift (in_xfer && stored),
        .din   (taps[i-1]),
        .xc    (xc),
        .dout  (taps[i]),
        .diff  (diffs[i])
      );
    end
  end

  led_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .job        (job),
    .taps       (taps),
    .diffs      (diffs),
    .xc         (xc),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .peak_index (peak_index)
  );

endmodule
